### rtl/vpa_pkg.sv
// Shared types, constants and saturation helpers for the vector pairwise ALU.
package vpa_pkg;

    localparam int MAX_LEN   = 256;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int ACC_W     = 64;
    localparam int LEN_W     = 9;
    localparam int KIND_W    = 3;
    localparam int IDX_W     = 9;

    localparam logic [LEN_W-1:0]         LEN_ONE = LEN_W'(1);
    localparam logic [LEN_W-1:0]         LEN_MAX = LEN_W'(MAX_LEN);
    localparam logic signed [DATA_W-1:0] FX_ONE  = DATA_W'(1) << FRAC_BITS;

    // Operation codes; the error code doubles as the illegal kind value.
    typedef enum logic [KIND_W-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DOT = 3'd3,
        OP_OR  = 3'd4,
        OP_AND = 3'd5,
        OP_XOR = 3'd6,
        OP_ERR = 3'd7
    } t_op;

    // Command handed from the front end to the execution back end.
    typedef struct packed {
        t_op                      op;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic                     last;
    } t_cmd;

    // Clamp a 65-bit signed value to 32 bits.
    function automatic logic signed [DATA_W-1:0] f_sat32(input logic signed [ACC_W:0] v);
        logic fits;
        fits = (v[ACC_W:DATA_W-1] == {(ACC_W-DATA_W+2){v[ACC_W]}});
        if (fits) begin
            return v[DATA_W-1:0];
        end else if (v[ACC_W]) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

    // Clamp a 65-bit signed sum to 64 bits.
    function automatic logic signed [ACC_W-1:0] f_sat64(input logic signed [ACC_W:0] v);
        if (v[ACC_W] == v[ACC_W-1]) begin
            return v[ACC_W-1:0];
        end else if (v[ACC_W]) begin
            return {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            return {1'b0, {(ACC_W-1){1'b1}}};
        end
    endfunction

endpackage

### rtl/vpa_if.sv
// Valid/ready stream interfaces for element pairs in and results out.
interface vpa_in_if;
    logic                                     valid;
    logic                                     ready;
    logic [vpa_pkg::KIND_W-1:0]               kind;
    logic signed [vpa_pkg::DATA_W-1:0]        a_elem;
    logic signed [vpa_pkg::DATA_W-1:0]        b_elem;
    logic [vpa_pkg::LEN_W-1:0]                len_a;
    logic [vpa_pkg::LEN_W-1:0]                len_b;
    logic                                     last_in;

    modport source (output valid, kind, a_elem, b_elem, len_a, len_b, last_in, input ready);
    modport sink   (input valid, kind, a_elem, b_elem, len_a, len_b, last_in, output ready);
endinterface

interface vpa_out_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [vpa_pkg::DATA_W-1:0]        value;
    logic                                     status;
    logic                                     last_out;

    modport source (output valid, value, status, last_out, input ready);
    modport sink   (input valid, value, status, last_out, output ready);
endinterface

### rtl/vpa_front.sv
// Front end: accepts element pairs, checks dimensions and resolves mul operands.
module vpa_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    vpa_in_if.sink          i_in,
    input  logic            i_full,
    output logic            o_push,
    output vpa_pkg::t_cmd   o_cmd
);
    import vpa_pkg::*;

    logic [IDX_W-1:0]          r_idx, n_idx;
    logic signed [DATA_W-1:0]  r_scalar, n_scalar;
    logic                      r_failed, n_failed;

    logic                      w_acc;
    logic                      w_bad;
    logic                      w_bcast_a;
    logic                      w_bcast_b;
    logic                      w_first;
    logic signed [DATA_W-1:0]  w_scal;
    t_op                       w_op;

    assign i_in.ready = !i_full;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_op       = t_op'(i_in.kind);

    always_comb begin
        w_bad = (w_op == OP_ERR)
             || (i_in.len_a == '0) || (i_in.len_b == '0)
             || (i_in.len_a > LEN_MAX) || (i_in.len_b > LEN_MAX);
        if ((i_in.len_a != i_in.len_b)
            && !((w_op == OP_MUL) && ((i_in.len_a == LEN_ONE) || (i_in.len_b == LEN_ONE)))) begin
            w_bad = 1'b1;
        end
    end

    // A length-one side of a mul is a scalar, taken on the run's first item.
    assign w_bcast_a = (i_in.len_a == LEN_ONE) && (i_in.len_b != LEN_ONE);
    assign w_bcast_b = (i_in.len_b == LEN_ONE) && (i_in.len_a != LEN_ONE);
    assign w_first   = (r_idx == '0);
    assign w_scal    = !w_first ? r_scalar : (w_bcast_a ? i_in.a_elem : i_in.b_elem);

    always_comb begin
        o_cmd.op   = w_bad ? OP_ERR : w_op;
        o_cmd.x    = i_in.a_elem;
        o_cmd.y    = i_in.b_elem;
        o_cmd.last = i_in.last_in;
        if (w_op == OP_MUL && w_bcast_a) begin
            o_cmd.x = w_scal;
        end
        if (w_op == OP_MUL && w_bcast_b) begin
            o_cmd.y = w_scal;
        end
    end

    assign o_push = w_acc && !r_failed;

    always_comb begin
        n_idx    = r_idx;
        n_scalar = r_scalar;
        n_failed = r_failed;
        if (w_acc) begin
            if (!r_failed) begin
                if (w_bad) begin
                    n_failed = 1'b1;
                end else begin
                    if (r_idx != '1) begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                    if (w_op == OP_MUL && (w_bcast_a || w_bcast_b) && w_first) begin
                        n_scalar = w_scal;
                    end
                end
            end
            if (i_in.last_in) begin
                n_idx    = '0;
                n_scalar = '0;
                n_failed = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_scalar <= '0;
            r_failed <= 1'b0;
        end else begin
            r_idx    <= n_idx;
            r_scalar <= n_scalar;
            r_failed <= n_failed;
        end
    end

    a_fail_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !r_failed && w_bad && !i_in.last_in) |=> r_failed)
        else $error("run not marked failed after a dimension error");

    a_failed_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |-> !o_push)
        else $error("command pushed during a failed run");

endmodule

### rtl/vpa_queue.sv
// Two-entry command queue between the front end and the back end.
module vpa_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  vpa_pkg::t_cmd   i_cmd,
    output logic            o_full,
    output logic            o_valid,
    output vpa_pkg::t_cmd   o_cmd,
    input  logic            i_pop
);
    import vpa_pkg::*;

    t_cmd        r_mem [2];
    logic        r_wr, r_rd;
    logic [1:0]  r_count, n_count;
    logic        w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd];
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (w_pop) begin
                r_rd <= !r_rd;
            end
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && o_full) |-> w_pop)
        else $error("push into a full queue");

endmodule

### rtl/vpa_back.sv
// Back end: two-stage execution (sum or product, then scale and accumulate).
module vpa_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  vpa_pkg::t_cmd   i_cmd,
    output logic            o_pop,
    vpa_out_if.source       o_out
);
    import vpa_pkg::*;

    logic                      w_en;

    // Stage E.
    logic signed [DATA_W:0]    w_sum;
    logic signed [ACC_W-1:0]   w_prod;
    logic signed [DATA_W-1:0]  n_e_small;
    logic                      r_e_valid;
    t_op                       r_e_op;
    logic signed [DATA_W-1:0]  r_e_small;
    logic signed [ACC_W-1:0]   r_e_prod;
    logic                      r_e_last;

    // Stage F.
    logic signed [ACC_W-1:0]   w_shift;
    logic signed [ACC_W:0]     w_acc_sum;
    logic signed [ACC_W-1:0]   w_acc_new;
    logic signed [DATA_W-1:0]  n_o_value;
    logic                      w_emit;
    logic signed [ACC_W-1:0]   r_acc;

    logic                      r_o_valid;
    logic signed [DATA_W-1:0]  r_o_value;
    logic                      r_o_status;
    logic                      r_o_last;

    assign w_en  = !r_o_valid || o_out.ready;
    assign o_pop = w_en && i_valid;

    assign w_sum  = (i_cmd.op == OP_SUB)
                  ? ($signed({i_cmd.x[DATA_W-1], i_cmd.x}) - $signed({i_cmd.y[DATA_W-1], i_cmd.y}))
                  : ($signed({i_cmd.x[DATA_W-1], i_cmd.x}) + $signed({i_cmd.y[DATA_W-1], i_cmd.y}));
    assign w_prod = $signed(i_cmd.x) * $signed(i_cmd.y);

    always_comb begin
        case (i_cmd.op)
            OP_ADD, OP_SUB: n_e_small = f_sat32({{(ACC_W-DATA_W){w_sum[DATA_W]}}, w_sum});
            OP_OR:  n_e_small = ((i_cmd.x != '0) || (i_cmd.y != '0)) ? FX_ONE : '0;
            OP_AND: n_e_small = ((i_cmd.x != '0) && (i_cmd.y != '0)) ? FX_ONE : '0;
            OP_XOR: n_e_small = ((i_cmd.x != '0) != (i_cmd.y != '0)) ? FX_ONE : '0;
            default: n_e_small = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_op    <= i_cmd.op;
            r_e_small <= n_e_small;
            r_e_prod  <= w_prod;
            r_e_last  <= i_cmd.last;
        end
    end

    // Arithmetic shift is the floor of the scaled product.
    assign w_shift   = r_e_prod >>> FRAC_BITS;
    assign w_acc_sum = $signed({r_acc[ACC_W-1], r_acc}) + $signed({w_shift[ACC_W-1], w_shift});
    assign w_acc_new = f_sat64(w_acc_sum);
    assign w_emit    = (r_e_op != OP_DOT) || r_e_last;

    always_comb begin
        case (r_e_op)
            OP_MUL:  n_o_value = f_sat32({w_shift[ACC_W-1], w_shift});
            OP_DOT:  n_o_value = f_sat32({w_acc_new[ACC_W-1], w_acc_new});
            OP_ERR:  n_o_value = '0;
            default: n_o_value = r_e_small;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_value  <= n_o_value;
            r_o_status <= (r_e_op == OP_ERR);
            r_o_last   <= (r_e_op == OP_ERR) || r_e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_acc     <= '0;
        end else if (w_en) begin
            r_e_valid <= i_valid;
            r_o_valid <= r_e_valid && w_emit;
            if (r_e_valid) begin
                if (r_e_op == OP_ERR || r_e_last) begin
                    r_acc <= '0;
                end else if (r_e_op == OP_DOT) begin
                    r_acc <= w_acc_new;
                end
            end
        end
    end

    assign o_out.valid    = r_o_valid;
    assign o_out.value    = r_o_value;
    assign o_out.status   = r_o_status;
    assign o_out.last_out = r_o_last;

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status) |-> (r_o_last && r_o_value == '0))
        else $error("error result not a zero last item");

    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_e_valid && (r_e_last || r_e_op == OP_ERR)) |=> (r_acc == '0))
        else $error("dot accumulator not cleared at end of run");

endmodule

### rtl/vector_pairwise_alu.sv
// Top level of the vector pairwise ALU: front end, command queue, back end.
// Path: a transferred item is written into the command queue, then into stage E, then into the output register.
// Throughput: one element pair per cycle while the result side is ready, set by the 32x32 multiply stage
// and the 64-bit saturating accumulate that closes the dot loop.
// Reset: synchronous, active low; clears run state, dot accumulator, queue and valid flags.
module vector_pairwise_alu (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vpa_in_if.sink     i_in,
    vpa_out_if.source  o_out
);
    import vpa_pkg::*;

    // Front to queue.
    logic  w_push;
    logic  w_full;
    t_cmd  w_push_cmd;

    // Queue to back end.
    logic  w_q_valid;
    logic  w_pop;
    t_cmd  w_q_cmd;

    // Front end: take one pair per transfer, track run index, broadcast scalar and the
    // failed-run flag, and turn each pair into a command (or drop it in a failed run).
    vpa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    // Short queue: lets the front keep taking pairs while the back end holds a result.
    vpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_pop)
    );

    // Back end: compute, saturate, accumulate dot sums and hold the output register.
    vpa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_cmd   (w_q_cmd),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

### test/vector_pairwise_alu_tb.sv
// Self-checking testbench for the vector pairwise ALU: directed table, random runs, predictor.
module vector_pairwise_alu_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vpa_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RANDOM_ITEMS = 550;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 100000;

    localparam logic ST_OK      = 1'b0;
    localparam logic ST_DIM_ERR = 1'b1;

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0]  ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0]  ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [IDX_W-1:0]         IDX_TOP  = {IDX_W{1'b1}};

    // How a directed row is judged: by the predictor, as yielding no result, or by a value typed into the table.
    typedef enum logic [1:0] {
        BY_MODEL,
        NO_RESULT,
        TYPED
    } t_chk;

    typedef struct {
        t_op                      kind;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        logic [LEN_W-1:0]         len_a;
        logic [LEN_W-1:0]         len_b;
        logic                     last;
    } t_elem_pair;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     status;
        logic                     last;
    } t_result;

    typedef struct {
        t_elem_pair pair;
        t_chk       chk;
        t_result    want;
    } t_script_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    vpa_in_if  pair_if ();
    vpa_out_if res_if ();

    vector_pairwise_alu uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (pair_if),
        .o_out   (res_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Predictor state for the run in progress.
    logic [IDX_W-1:0]         pos_in_run;
    logic signed [DATA_W-1:0] bcast_scalar;
    logic signed [ACC_W-1:0]  dot_sum;
    bit                       run_dead;

    t_result     expected_q[$];
    t_script_row script[$];

    int  mismatch_count = 0;
    int  pairs_sent     = 0;
    int  directed_sent  = 0;
    int  results_seen   = 0;
    int  errors_seen    = 0;
    int  cycle_count    = 0;
    bit  src_calm       = 1'b0;
    bit  sink_calm      = 1'b0;
    int  stall_left     = 0;

    // ---------------------------------------------------------------- predictor

    function automatic void clear_run_state();
        pos_in_run   = '0;
        bcast_scalar = '0;
        dot_sum      = '0;
        run_dead     = 1'b0;
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp32(input logic signed [ACC_W-1:0] v);
        if (v > DATA_MAX) return DATA_MAX;
        if (v < DATA_MIN) return DATA_MIN;
        return v[DATA_W-1:0];
    endfunction

    // Full 64-bit product, then drop the fraction bits rounding toward minus infinity.
    function automatic logic signed [ACC_W-1:0] fx_product(input logic signed [DATA_W-1:0] x,
                                                            input logic signed [DATA_W-1:0] y);
        logic signed [ACC_W-1:0] full;
        full = x * y;
        return full >>> FRAC_BITS;
    endfunction

    function automatic logic signed [ACC_W-1:0] acc_add(input logic signed [ACC_W-1:0] acc,
                                                        input logic signed [ACC_W-1:0] inc);
        if (inc > 0 && acc > ACC_MAX - inc) return ACC_MAX;
        if (inc < 0 && acc < ACC_MIN - inc) return ACC_MIN;
        return acc + inc;
    endfunction

    function automatic bit truth(input logic signed [DATA_W-1:0] x);
        return x != 0;
    endfunction

    function automatic logic signed [DATA_W-1:0] flag_value(input bit t);
        return t ? FX_ONE : '0;
    endfunction

    // Advance the predictor by one transferred pair; return 1 when it yields a result.
    function automatic bit model_pair(input t_elem_pair p, output t_result r);
        bit                      bad;
        bit                      emits;
        logic signed [ACC_W-1:0] v;
        r = '{value: '0, status: ST_OK, last: 1'b0};
        v = '0;
        if (run_dead) begin
            if (p.last) clear_run_state();
            return 1'b0;
        end
        bad = (p.kind == OP_ERR) || (p.len_a == 0) || (p.len_b == 0)
              || (p.len_a > LEN_MAX) || (p.len_b > LEN_MAX);
        if (p.len_a != p.len_b
            && !(p.kind == OP_MUL && (p.len_a == LEN_ONE || p.len_b == LEN_ONE)))
            bad = 1'b1;
        if (bad) begin
            r.status = ST_DIM_ERR;
            r.last   = 1'b1;
            run_dead = 1'b1;
            if (p.last) clear_run_state();
            return 1'b1;
        end
        case (p.kind)
            OP_ADD: v = clamp32(ACC_W'(p.a) + ACC_W'(p.b));
            OP_SUB: v = clamp32(ACC_W'(p.a) - ACC_W'(p.b));
            OP_MUL: begin
                if (p.len_a == LEN_ONE && p.len_b != LEN_ONE) begin
                    if (pos_in_run == 0) bcast_scalar = p.a;
                    v = clamp32(fx_product(bcast_scalar, p.b));
                end else if (p.len_b == LEN_ONE && p.len_a != LEN_ONE) begin
                    if (pos_in_run == 0) bcast_scalar = p.b;
                    v = clamp32(fx_product(p.a, bcast_scalar));
                end else begin
                    v = clamp32(fx_product(p.a, p.b));
                end
            end
            OP_DOT: begin
                dot_sum = acc_add(dot_sum, fx_product(p.a, p.b));
                v = clamp32(dot_sum);
            end
            OP_OR:  v = flag_value(truth(p.a) || truth(p.b));
            OP_AND: v = flag_value(truth(p.a) && truth(p.b));
            default: v = flag_value(truth(p.a) != truth(p.b));
        endcase
        emits = (p.kind != OP_DOT) || p.last;
        r.value = v[DATA_W-1:0];
        r.last  = p.last;
        if (pos_in_run != IDX_TOP) pos_in_run++;
        if (p.last) clear_run_state();
        return emits;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic int draw_gap();
        return src_calm ? 0 : $urandom_range(0, 4);
    endfunction

    // Mix of corners, small fixed-point values, zeros (for the logic kinds) and raw bits.
    function automatic logic signed [DATA_W-1:0] draw_elem();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return DATA_MAX;
                    1: return DATA_MIN;
                    2: return -1;
                    default: return FX_ONE;
                endcase
            end
            1, 2, 3: return 32'($urandom_range(0, 1 << 20)) - (1 << 19);
            4, 5:    return '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_row(input t_op k, input logic signed [DATA_W-1:0] a,
                           input logic signed [DATA_W-1:0] b,
                           input logic [LEN_W-1:0] la, input logic [LEN_W-1:0] lb,
                           input logic last, input t_chk chk,
                           input logic signed [DATA_W-1:0] v = '0,
                           input logic st = ST_OK, input logic lo = 1'b0);
        t_script_row row;
        row.pair = '{kind: k, a: a, b: b, len_a: la, len_b: lb, last: last};
        row.chk  = chk;
        row.want = '{value: v, status: st, last: lo};
        script.push_back(row);
    endtask

    // Present one pair after an optional gap and hold it until the transfer edge.
    task automatic push_pair(input t_elem_pair p, input int gap);
        if (gap > 0) begin
            pair_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pair_if.valid   <= 1'b1;
        pair_if.kind    <= p.kind;
        pair_if.a_elem  <= p.a;
        pair_if.b_elem  <= p.b;
        pair_if.len_a   <= p.len_a;
        pair_if.len_b   <= p.len_b;
        pair_if.last_in <= p.last;
        @(posedge i_clk);
        while (!pair_if.ready) @(posedge i_clk);
        pairs_sent++;
    endtask

    // One random run: pick kind and lengths, then stream its pairs up to the last flag.
    task automatic stream_random_run();
        t_op              k;
        logic [LEN_W-1:0] la;
        logic [LEN_W-1:0] lb;
        int               pick;
        int               n;
        t_elem_pair       p;
        t_result          r;
        pick = $urandom_range(0, 99);
        k = t_op'($urandom_range(0, 6));
        if ($urandom_range(0, 29) == 0) k = OP_ERR;
        if (pick < 65) begin
            la = LEN_W'($urandom_range(1, 8));
            lb = la;
        end else if (pick < 72) begin
            la = $urandom_range(0, 1) ? LEN_MAX : LEN_W'($urandom_range(9, MAX_LEN - 1));
            lb = la;
        end else if (pick < 84) begin
            // scalar broadcast: one side of length one
            k  = OP_MUL;
            la = LEN_ONE;
            lb = LEN_W'($urandom_range(2, 12));
            if ($urandom_range(0, 1)) {la, lb} = {lb, la};
        end else if (pick < 92) begin
            la = LEN_W'($urandom_range(1, MAX_LEN));
            lb = LEN_W'($urandom_range(1, MAX_LEN));
        end else begin
            la = LEN_W'($urandom_range(0, 511));
            lb = $urandom_range(0, 1) ? LEN_W'(0) : LEN_W'($urandom_range(MAX_LEN + 1, 511));
            if ($urandom_range(0, 1)) {la, lb} = {lb, la};
        end
        n = int'((la > lb) ? la : lb);
        if (n == 0 || n > 12) n = $urandom_range(1, 12);
        if ($urandom_range(0, 9) == 0) n = $urandom_range(1, 6);
        src_calm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++) begin
            p.kind = k;
            if ($urandom_range(0, 39) == 0) p.kind = t_op'($urandom_range(0, 7));
            p.a     = draw_elem();
            p.b     = draw_elem();
            p.len_a = la;
            p.len_b = lb;
            p.last  = (i == n - 1);
            push_pair(p, draw_gap());
            if (model_pair(p, r)) expected_q.push_back(r);
        end
    endtask

    // ---------------------------------------------------------------- main sequence

    initial begin : main_seq
        t_result r;
        pair_if.valid   <= 1'b0;
        pair_if.kind    <= OP_ADD;
        pair_if.a_elem  <= '0;
        pair_if.b_elem  <= '0;
        pair_if.len_a   <= '0;
        pair_if.len_b   <= '0;
        pair_if.last_in <= 1'b0;
        i_rst_n         <= 1'b0;
        clear_run_state();

        // saturation and extremes
        add_row(OP_ADD, DATA_MAX, DATA_MAX, 1, 1, 1, TYPED, DATA_MAX, ST_OK, 1);
        add_row(OP_SUB, DATA_MIN, DATA_MAX, 1, 1, 1, TYPED, DATA_MIN, ST_OK, 1);
        add_row(OP_ADD, DATA_MAX, DATA_MIN, LEN_MAX, LEN_MAX, 1, TYPED, -1, ST_OK, 1);
        add_row(OP_MUL, FX_ONE, DATA_MIN, 1, 1, 1, TYPED, DATA_MIN, ST_OK, 1);
        add_row(OP_MUL, -1, 1, 2, 2, 0, BY_MODEL);
        add_row(OP_MUL, DATA_MAX, DATA_MAX, 2, 2, 1, TYPED, DATA_MAX, ST_OK, 1);
        // dot: silent until the last pair, then one clamped sum
        add_row(OP_DOT, 32'sh0003_0000, 32'sh0002_0000, 3, 3, 0, NO_RESULT);
        add_row(OP_DOT, 32'shFFFF_8000, FX_ONE, 3, 3, 0, NO_RESULT);
        add_row(OP_DOT, 32'sh1234_5678, 32'sh9ABC_DEF0, 3, 3, 1, BY_MODEL);
        add_row(OP_DOT, DATA_MAX, DATA_MAX, 1, 1, 1, TYPED, DATA_MAX, ST_OK, 1);
        // logic kinds on element truth
        add_row(OP_OR, 0, 0, 2, 2, 0, TYPED, 0, ST_OK, 0);
        add_row(OP_OR, 0, 5, 2, 2, 1, TYPED, FX_ONE, ST_OK, 1);
        add_row(OP_AND, DATA_MIN, -1, 1, 1, 1, TYPED, FX_ONE, ST_OK, 1);
        add_row(OP_XOR, 1, 1, 2, 2, 0, TYPED, 0, ST_OK, 0);
        add_row(OP_XOR, 0, DATA_MIN, 2, 2, 1, TYPED, FX_ONE, ST_OK, 1);
        // scalar broadcast from either side, latched on the first pair
        add_row(OP_MUL, 32'sh0002_8000, FX_ONE, 1, 3, 0, BY_MODEL);
        add_row(OP_MUL, DATA_MAX, 32'shFFFE_0000, 1, 3, 0, BY_MODEL);
        add_row(OP_MUL, 0, 32'sh0000_4000, 1, 3, 1, BY_MODEL);
        add_row(OP_MUL, 32'sh0003_0000, 32'shFFFE_0000, 2, 1, 0, BY_MODEL);
        add_row(OP_MUL, 32'sh0000_1000, DATA_MAX, 2, 1, 1, BY_MODEL);
        // length mismatch kills the run; the rest is dropped until last
        add_row(OP_ADD, 1, 1, 2, 3, 0, TYPED, 0, ST_DIM_ERR, 1);
        add_row(OP_ADD, 5, 5, 2, 2, 1, NO_RESULT);
        // zero length, oversize length, illegal kind, mul without a unit side
        add_row(OP_SUB, 0, 0, 0, 0, 1, TYPED, 0, ST_DIM_ERR, 1);
        add_row(OP_XOR, 0, 0, 511, 300, 1, TYPED, 0, ST_DIM_ERR, 1);
        add_row(OP_ERR, 1, 2, 4, 4, 1, TYPED, 0, ST_DIM_ERR, 1);
        add_row(OP_MUL, 1, 1, 3, 4, 1, TYPED, 0, ST_DIM_ERR, 1);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            push_pair(script[i].pair, draw_gap());
            if (model_pair(script[i].pair, r) && script[i].chk == BY_MODEL)
                expected_q.push_back(r);
            if (script[i].chk == TYPED) expected_q.push_back(script[i].want);
        end
        directed_sent = pairs_sent;

        while (pairs_sent - directed_sent < RANDOM_ITEMS) stream_random_run();
        pair_if.valid <= 1'b0;

        // drain: wait for every expected result, then watch for strays
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d element pairs (%0d from the directed table), checked %0d results",
                 pairs_sent, directed_sent, results_seen);
        $display("of which %0d were dimension errors; %0d mismatches", errors_seen,
                 mismatch_count);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // ---------------------------------------------------------------- result side

    // Compare each transfer against the oldest expectation, then draw the next stall.
    always @(posedge i_clk) begin : result_sink
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            if (res_if.status == ST_DIM_ERR) errors_seen++;
            if (expected_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result: value %h status %0b last %0b", $time,
                         res_if.value, res_if.status, res_if.last_out);
            end else begin
                want = expected_q.pop_front();
                if (res_if.value !== want.value || res_if.status !== want.status
                    || res_if.last_out !== want.last) begin
                    mismatch_count++;
                    $display("%0t: expected value %h status %0b last %0b, got %h %0b %0b",
                             $time, want.value, want.status, want.last,
                             res_if.value, res_if.status, res_if.last_out);
                end
            end
            stall_left = sink_calm ? 0 : $urandom_range(0, 4);
            if ($urandom_range(0, 19) == 0) sink_calm = !sink_calm;
        end
        if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left--;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
                     cycle_count, expected_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule
